// ----- sv/oswc_pkg.sv -----
// shared types and constants of the word checksum core
`timescale 1ns / 1ps
package oswc_pkg;
    localparam int unsigned AccW  = 64;
    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 3;
    localparam int unsigned CntW  = 7;
    localparam int unsigned CfgIdxW = 3;

    typedef logic [AccW-1:0] t_acc;
    typedef logic [OpW-1:0]  t_op;

    localparam t_op OP_XOR = 3'd0;
    localparam t_op OP_ADD = 3'd1;
    localparam t_op OP_SUB = 3'd2;
    localparam t_op OP_MUL = 3'd3;
    localparam t_op OP_DIV = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_INIT_A  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_INIT_B  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INIT_C  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_VERSION = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OP0     = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OP1     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_OP2     = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_OP3     = 3'd7;

    function automatic logic [WordW-1:0] seed_of(input logic [2:0] idx);
        logic [WordW-1:0] s;
        unique case (idx)
            3'd0: s = 32'hE7F4CB62;
            3'd1: s = 32'hF6A14FFC;
            3'd2: s = 32'hAA5504AF;
            3'd3: s = 32'h871FCDC2;
            3'd4: s = 32'h11BF6A18;
            3'd5: s = 32'hC57292E6;
            3'd6: s = 32'h7927D27E;
            default: s = 32'h2FEC8733;
        endcase
        return s;
    endfunction
endpackage

// ----- sv/op_selectable_word_checksum_core.sv -----
// word checksum core with one shared iterative alu for the four operations
`timescale 1ns / 1ps
// Each input beat runs its four operations one after another on a single
// shared unit. xor, add, subtract and a divide by zero go through operand
// setup and writeback; multiply and divide are bit serial at one bit per cycle
// (setup, 64 steps, writeback). A beat that ends a run also passes through
// the output state. The input is not ready while a beat is in work; the
// result sits in an output register and the next beat is taken meanwhile.
// A second result waits until the first is taken.
module op_selectable_word_checksum_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // data_word
    input  logic        s_axis_tuser,  // first_word
    input  logic        s_axis_tlast,  // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // checksum
    output logic        m_axis_tuser   // divide_by_zero_seen
);
    import oswc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SET  = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [31:0] r_init_a, r_init_b, r_init_c;
    logic [2:0]  r_ver;
    t_op         r_op [4];
    t_acc        r_a, r_b, r_c;
    logic        r_dz;
    logic [31:0] r_word;
    logic        r_last;
    logic [2:0]  r_state;
    logic [1:0]  r_step;
    logic [CntW-1:0] r_cnt;
    t_acc        r_x, r_y, r_res, r_rem;
    logic        r_ovalid;
    logic [31:0] r_osum;
    logic        r_odz;

    t_op  w_op;
    t_acc w_x, w_y;
    logic [AccW:0] w_trial;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_osum;
    assign m_axis_tuser  = r_odz;

    assign w_op = r_op[r_step];
    always_comb begin
        unique case (r_step)
            2'd0: begin w_x = r_a; w_y = {32'd0, r_word}; end
            2'd1: begin w_x = r_b; w_y = r_c; end
            2'd2: begin w_x = r_c; w_y = r_a; end
            default: begin w_x = r_a; w_y = r_b; end
        endcase
    end

    // restoring division step
    assign w_trial = {r_rem, r_x[AccW-1]} - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_a <= '0; r_init_b <= '0; r_init_c <= '0; r_ver <= '0;
            for (int k = 0; k < 4; k++) r_op[k] <= OP_XOR;
            r_a <= '0; r_b <= '0; r_c <= '0; r_dz <= 1'b0;
            r_state <= ST_IDLE; r_step <= '0; r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_INIT_A:  r_init_a <= i_cfg_data;
                    REG_INIT_B:  r_init_b <= i_cfg_data;
                    REG_INIT_C:  r_init_c <= i_cfg_data;
                    REG_VERSION: r_ver <= i_cfg_data[2:0];
                    REG_OP0:     r_op[0] <= i_cfg_data[OpW-1:0];
                    REG_OP1:     r_op[1] <= i_cfg_data[OpW-1:0];
                    REG_OP2:     r_op[2] <= i_cfg_data[OpW-1:0];
                    default:     r_op[3] <= i_cfg_data[OpW-1:0];
                endcase
            end
            if (r_ovalid && m_axis_tready && r_state != ST_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_word <= s_axis_tdata;
                        r_last <= s_axis_tlast;
                        r_step <= '0;
                        if (s_axis_tuser) begin
                            r_a <= {32'd0, r_init_a ^ seed_of(r_ver)};
                            r_b <= {32'd0, r_init_b};
                            r_c <= {32'd0, r_init_c};
                            r_dz <= 1'b0;
                        end
                        r_state <= ST_SET;
                    end
                end
                ST_SET: begin
                    r_x <= w_x; r_y <= w_y; r_cnt <= '0;
                    r_rem <= '0; r_res <= '0;
                    unique case (w_op)
                        OP_XOR: begin r_res <= w_x ^ w_y; r_state <= ST_DONE; end
                        OP_ADD: begin r_res <= w_x + w_y; r_state <= ST_DONE; end
                        OP_SUB: begin r_res <= w_x - w_y; r_state <= ST_DONE; end
                        OP_MUL: r_state <= ST_RUN;
                        OP_DIV: begin
                            if (w_y == '0) begin
                                r_res <= '1; r_dz <= 1'b1; r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_RUN;
                            end
                        end
                        default: begin r_res <= w_x; r_state <= ST_DONE; end
                    endcase
                end
                ST_RUN: begin
                    if (w_op == OP_MUL) begin
                        // shift-add, multiplier bits lsb first
                        r_res <= r_res + (r_y[0] ? r_x : '0);
                        r_x   <= r_x << 1;
                        r_y   <= r_y >> 1;
                    end else begin
                        r_x <= r_x << 1;
                        if (!w_trial[AccW]) begin
                            r_rem <= w_trial[AccW-1:0];
                            r_res <= {r_res[AccW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[AccW-2:0], r_x[AccW-1]};
                            r_res <= {r_res[AccW-2:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CntW'(AccW - 1)) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    unique case (r_step)
                        2'd0: r_a <= r_res;
                        2'd1: r_b <= r_res;
                        2'd2: r_c <= r_res;
                        default: r_a <= r_res;
                    endcase
                    if (r_step == 2'd3) begin
                        r_state <= r_last ? ST_OUT : ST_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                        r_state <= ST_SET;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_osum <= r_c[31:0];
                        r_odz <= r_dz;
                        r_ovalid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_ovalid)
        else $error("result not posted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (w_op == OP_MUL || w_op == OP_DIV))
        else $error("iterating on a single-cycle op");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_step != 2'd3) |=> (r_state == ST_SET))
        else $error("step sequence broken");
endmodule
